// ----- src/mse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, letter tables and the byte-to-segment plan builder.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned MAX_SEGS = 8;

  typedef logic [1:0] units_t;
  localparam units_t UNITS_ONE   = 2'd0;
  localparam units_t UNITS_THREE = 2'd1;
  localparam units_t UNITS_FOUR  = 2'd2;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  localparam logic [2:0] SYM_COUNT [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  localparam logic [3:0] SYM_BITS [26] = '{
    4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0, 4'h7, 4'h5, 4'h4, 4'h3,
    4'h2, 4'h7, 4'h6, 4'hD, 4'h2, 4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC
  };

  typedef struct packed {
    logic [3:0]              count;
    logic [MAX_SEGS-1:0]     tone;
    units_t [MAX_SEGS-1:0]   units;
  } plan_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return is_upper(c) || is_lower(c);
  endfunction

  function automatic plan_t build_plan(input logic [7:0] c, input logic word_start);
    plan_t      p;
    logic [7:0] off;
    logic [4:0] idx;
    logic [2:0] len;
    logic [3:0] bits;
    logic [3:0] n;
    logic [2:0] sh;
    logic       dash;
    p    = '0;
    n    = 4'd0;
    off  = is_upper(c) ? (c - CHAR_UPPER_A) : (c - CHAR_LOWER_A);
    idx  = off[4:0];
    len  = 3'd0;
    bits = 4'd0;
    if (c == CHAR_SPACE) begin
      p.tone[0]  = 1'b0;
      p.units[0] = UNITS_FOUR;
      n = 4'd1;
    end else if (is_letter(c)) begin
      len  = SYM_COUNT[idx];
      bits = SYM_BITS[idx];
      if (!word_start) begin
        p.tone[n[2:0]]  = 1'b0;
        p.units[n[2:0]] = UNITS_THREE;
        n = n + 4'd1;
      end
      for (int j = 0; j < 4; j++) begin
        if (3'(j) < len) begin
          sh   = len - 3'd1 - 3'(j);
          dash = bits[sh[1:0]];
          if (j > 0) begin
            p.tone[n[2:0]]  = 1'b0;
            p.units[n[2:0]] = UNITS_ONE;
            n = n + 4'd1;
          end
          p.tone[n[2:0]]  = 1'b1;
          p.units[n[2:0]] = dash ? UNITS_THREE : UNITS_ONE;
          n = n + 4'd1;
        end
      end
    end
    p.count = n;
    return p;
  endfunction

endpackage

// ----- src/mse_emitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_emitter
// Walks a held segment plan, driving one segment per cycle (unless stalled)
// into the result register and scaling each segment by the unit length.
// ----------------------------------------------------------------------------
module mse_emitter
  import mse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        plan_valid,
  input  plan_t       plan,
  input  logic [15:0] unit_length,
  output logic        plan_done,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tone_on,
  output logic [17:0] duration,
  output logic        last_of_run
);

  logic [2:0]  idx;
  logic        load;
  logic        last;
  units_t      seg_units;
  logic [17:0] dur_next;
  logic [17:0] unit_ext;

  assign load      = plan_valid && (!out_valid || !out_stall);
  assign last      = ({1'b0, idx} == (plan.count - 4'd1));
  assign plan_done = load && last;
  assign seg_units = plan.units[idx];
  assign unit_ext  = {2'b00, unit_length};

  always_comb begin
    unique case (seg_units)
      UNITS_ONE:   dur_next = unit_ext;
      UNITS_THREE: dur_next = (unit_ext << 1) + unit_ext;
      UNITS_FOUR:  dur_next = unit_ext << 2;
      default:     dur_next = unit_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      idx       <= last ? 3'd0 : idx + 3'd1;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tone_on     <= plan.tone[idx];
      duration    <= dur_next;
      last_of_run <= last;
    end
  end

  a_idx_in_plan: assert property (@(posedge clk) disable iff (rst)
    plan_valid |-> ({1'b0, idx} < plan.count))
    else $error("segment index beyond plan");

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> plan_valid && (idx != 3'd0))
    else $error("non-final segment without remaining plan");

  a_last_rewinds: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> (idx == 3'd0))
    else $error("index not rewound after final segment");

endmodule

// ----- src/morse_segment_encoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_segment_encoder_unit
// Text byte to Morse keying segment encoder.
// ----------------------------------------------------------------------------
// Each accepted byte is decoded at once into a plan of up to eight segments
// (tone or silence, 1, 3 or 4 units long) which is held in a plan register
// and delivered one segment per cycle through the result register when the
// output is not stalled; bytes that are neither letters nor space give
// nothing. The next request is taken in the cycle the current plan hands over
// its final segment, so a steady stream of letters and spaces keeps the result
// channel busy every cycle. The user writes unit_length through cfg_we /
// cfg_wdata only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module morse_segment_encoder_unit
  import mse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tone_on,
  output logic [17:0] duration,
  output logic        last_of_run
);

  logic [15:0] unit_length;
  logic        word_start;
  logic        plan_valid;
  plan_t       plan;
  plan_t       plan_next;
  logic        plan_done;
  logic        accept;

  assign in_stall  = plan_valid && !plan_done;
  assign accept    = in_valid && !in_stall;
  assign plan_next = build_plan(char_code, word_start);

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_length <= 16'd4800;
    end else if (cfg_we) begin
      unit_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_start <= 1'b1;
      plan_valid <= 1'b0;
    end else begin
      if (accept && (char_code == CHAR_SPACE)) begin
        word_start <= 1'b1;
      end else if (accept && is_letter(char_code)) begin
        word_start <= 1'b0;
      end
      if (accept && (plan_next.count != 4'd0)) begin
        plan_valid <= 1'b1;
      end else if (plan_done) begin
        plan_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (plan_next.count != 4'd0)) begin
      plan <= plan_next;
    end
  end

  mse_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .plan_valid  (plan_valid),
    .plan        (plan),
    .unit_length (unit_length),
    .plan_done   (plan_done),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tone_on     (tone_on),
    .duration    (duration),
    .last_of_run (last_of_run)
  );

  a_plan_nonempty: assert property (@(posedge clk) disable iff (rst)
    plan_valid |-> (plan.count != 4'd0) && (plan.count <= 4'd8))
    else $error("held plan has bad segment count");

  a_letter_clears_word: assert property (@(posedge clk) disable iff (rst)
    accept && is_letter(char_code) |=> !word_start)
    else $error("word start not cleared by letter");

  a_space_one_segment: assert property (@(posedge clk) disable iff (rst)
    accept && (char_code == CHAR_SPACE) |=> plan_valid && (plan.count == 4'd1))
    else $error("space did not yield a single segment");

endmodule

// ----- sim/tb_morse_segment_encoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morse_segment_encoder_unit
// Self-checking testbench for the text byte to Morse keying segment encoder.
// Drives directed and random text bytes with random gaps and output stalls,
// sweeps unit_length across its extremes, and compares every segment with
// an independent segment planner built on the letter patterns as text.
// ----------------------------------------------------------------------------

typedef struct {
  logic        tone;
  logic [17:0] duration;
  logic        last;
} keying_seg_t;

class keying_scoreboard;
  logic [15:0] unit_len;
  bit          at_word_start;
  string       morse_pattern [26];
  keying_seg_t seg_store [64];
  int          rd_ptr;
  int          wr_ptr;
  int          fill;
  int          mismatches;

  function new();
    unit_len      = 16'd4800;
    at_word_start = 1'b1;
    rd_ptr        = 0;
    wr_ptr        = 0;
    fill          = 0;
    mismatches    = 0;
    morse_pattern = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                      ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                      "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  function void add_segment(bit tone, int units, bit last);
    keying_seg_t s;
    s.tone     = tone;
    s.duration = 18'(units * unit_len);
    s.last     = last;
    if (fill == $size(seg_store)) begin
      report("expected segment store overflow");
      return;
    end
    seg_store[wr_ptr] = s;
    wr_ptr = (wr_ptr + 1) % $size(seg_store);
    fill++;
  endfunction

  function void note_request(logic [7:0] c);
    int    idx;
    string pat;
    if (c == mse_pkg::CHAR_SPACE) begin
      add_segment(1'b0, 4, 1'b1);
      at_word_start = 1'b1;
      return;
    end
    if (c >= mse_pkg::CHAR_UPPER_A && c <= mse_pkg::CHAR_UPPER_Z)
      idx = c - mse_pkg::CHAR_UPPER_A;
    else if (c >= mse_pkg::CHAR_LOWER_A && c <= mse_pkg::CHAR_LOWER_Z)
      idx = c - mse_pkg::CHAR_LOWER_A;
    else
      return;
    pat = morse_pattern[idx];
    if (!at_word_start)
      add_segment(1'b0, 3, 1'b0);
    at_word_start = 1'b0;
    for (int j = 0; j < pat.len(); j++) begin
      if (j > 0)
        add_segment(1'b0, 1, 1'b0);
      add_segment(1'b1, (pat[j] == "-") ? 3 : 1, j == pat.len() - 1);
    end
  endfunction

  function void check_segment(logic tone, logic [17:0] dur, logic last);
    keying_seg_t exp_s;
    if (fill == 0) begin
      report($sformatf("unexpected segment tone=%0b duration=%0d last=%0b",
                       tone, dur, last));
      return;
    end
    exp_s  = seg_store[rd_ptr];
    rd_ptr = (rd_ptr + 1) % $size(seg_store);
    fill--;
    if (tone !== exp_s.tone || dur !== exp_s.duration || last !== exp_s.last)
      report($sformatf({"expected tone=%0b duration=%0d last=%0b, ",
                        "got tone=%0b duration=%0d last=%0b"},
                       exp_s.tone, exp_s.duration, exp_s.last, tone, dur, last));
  endfunction

  function int pending();
    return fill;
  endfunction
endclass

module tb_morse_segment_encoder_unit
  import mse_pkg::*;
();

  logic        clk;
  logic        rst         = 1'b1;
  logic        cfg_we      = 1'b0;
  logic [15:0] cfg_wdata   = 16'd0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code   = 8'd0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic        tone_on;
  logic [17:0] duration;
  logic        last_of_run;

  keying_scoreboard sb;
  int               stall_left = 0;
  bit               rx_quiet   = 1'b0;
  bit               tx_burst   = 1'b0;

  logic [7:0] opening_text [22] = '{
    8'h41, 8'h7A, 8'h20, 8'h20, 8'h51, 8'h00, 8'h79, 8'hFF, 8'h40, 8'h5B, 8'h60,
    8'h7B, 8'h5A, 8'h61, 8'h1F, 8'h21, 8'h45, 8'h74, 8'h20, 8'h6A, 8'h80, 8'h4D
  };

  logic [15:0] unit_sweep [5];

  morse_segment_encoder_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tone_on     (tone_on),
    .duration    (duration),
    .last_of_run (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("morse_segment_encoder_unit regression: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(6, 40);
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 149) == 0)
      rx_quiet <= !rx_quiet;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (rx_quiet || $urandom_range(0, 99) < 65) begin
      out_stall <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_stall  <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_segment(tone_on, duration, last_of_run);
  end

  // hold the request until taken; valid stays high when the next one follows at once
  task automatic send_char(input logic [7:0] c);
    int gap;
    if ($urandom_range(0, 29) == 0)
      tx_burst = !tx_burst;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(c);
  endtask

  task automatic write_unit(input logic [15:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    sb.unit_len = v;
  endtask

  task automatic random_text(input int count);
    int         sent;
    int         r;
    logic [7:0] c;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        c = ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'($urandom_range(0, 25));
      end else if (r < 83) begin
        c = CHAR_SPACE;
      end else begin
        c = 8'($urandom_range(0, 255));
      end
      send_char(c);
      sent++;
    end
  endtask

  initial begin
    sb = new();
    unit_sweep = '{16'd1, 16'd65535, 16'd0, 16'($urandom_range(2, 65534)), 16'd3};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (opening_text[i])
      send_char(opening_text[i]);
    random_text(56);
    foreach (unit_sweep[i]) begin
      write_unit(unit_sweep[i]);
      random_text(56);
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d segments never arrived", sb.pending()));
    if (sb.mismatches == 0)
      $display("morse_segment_encoder_unit regression: pass");
    else
      $display("morse_segment_encoder_unit regression: fail");
    $finish;
  end

endmodule
